FILE: rtl/ccf_pkg.sv
package ccf_pkg;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int RADIUS_W = 31;
  localparam int ACC_W    = 34;
  localparam int ATAN_W   = 30;
  localparam int GAIN_W   = 31;

  // parameter limits
  localparam int ITER_MIN = 8;
  localparam int ITER_MAX = 32;
  localparam int FRAC_MIN = 8;
  localparam int FRAC_MAX = 24;

  // angle constants
  localparam logic signed [ACC_W-1:0]  PI_Q30     = 34'sd3373259426;
  localparam logic signed [DATA_W-1:0] PI_Q28     = 32'sd843314857;
  localparam logic signed [DATA_W-1:0] TWO_PI_Q28 = 32'sd1686629713;

  // output limits
  localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

  // atan(2^-i) in Q0.30, rounded toward zero
  localparam logic [ATAN_W-1:0] ATAN_Q30 [0:31] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // 1/K(n) in Q31
  function automatic logic [GAIN_W-1:0] inv_gain(input int n);
    logic [GAIN_W-1:0] g;
    case (n)
      8: begin
        g = 31'd1304079014;
      end
      9: begin
        g = 31'd1304069065;
      end
      10: begin
        g = 31'd1304066577;
      end
      11: begin
        g = 31'd1304065955;
      end
      12: begin
        g = 31'd1304065800;
      end
      13: begin
        g = 31'd1304065761;
      end
      14: begin
        g = 31'd1304065751;
      end
      15: begin
        g = 31'd1304065749;
      end
      default: begin
        g = 31'd1304065748;
      end
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
  } ccf_in_t;

  typedef struct packed {
    logic        [RADIUS_W-1:0] radius;
    logic signed [DATA_W-1:0]   azimuth;
    logic signed [DATA_W-1:0]   height;
    logic signed [DATA_W-1:0]   field_radial;
    logic signed [DATA_W-1:0]   field_azimuthal;
    logic signed [DATA_W-1:0]   field_axial;
    logic                       saturated;
  } ccf_out_t;

  // values that ride along the chain untouched
  typedef struct packed {
    logic                     on_axis;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
  } ccf_side_t;

endpackage

FILE: rtl/ccf_in_if.sv
interface ccf_in_if;
  logic             valid;
  logic             ready;
  ccf_pkg::ccf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ccf_out_if.sv
interface ccf_out_if;
  logic              valid;
  logic              ready;
  ccf_pkg::ccf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cartesian_to_cylindrical_field_unit.sv
// channel   | dir | payload                                      | transfer when
// ----------+-----+----------------------------------------------+---------------
// sample    | in  | pos_x/y/z, field_x/y/z (Q15.16)               | valid & ready
// result    | out | radius, azimuth, height, field parts, flag   | valid & ready
// cfg       | in  | wrap_positive bit                            | cfg_we
//
// one item per cycle while the skid entry is free; a sample passes entry,
// the chain of rotation cells (one cell per iteration), three scaling
// stages and the output register.
// rst clears all stage valid bits, the output buffer and wrap_positive.
// the output register has one skid entry behind it; sample.ready drops only
// while that entry is full, and then the whole chain holds.
module cartesian_to_cylindrical_field_unit #(
  parameter int ITERATIONS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  ccf_in_if.sink          sample,
  ccf_out_if.source       result,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  localparam int N = (ITERATIONS < ccf_pkg::ITER_MIN) ? ccf_pkg::ITER_MIN :
                     ((ITERATIONS > ccf_pkg::ITER_MAX) ? ccf_pkg::ITER_MAX : ITERATIONS);
  localparam int F = (FRAC_BITS < ccf_pkg::FRAC_MIN) ? ccf_pkg::FRAC_MIN :
                     ((FRAC_BITS > ccf_pkg::FRAC_MAX) ? ccf_pkg::FRAC_MAX : FRAC_BITS);
  localparam int W = 34 + F;
  localparam logic [ccf_pkg::GAIN_W-1:0] GAIN = ccf_pkg::inv_gain(N);

  logic wrap;
  logic ce;

  logic                             c_valid [N+1];
  logic signed [W-1:0]              c_x     [N+1];
  logic signed [W-1:0]              c_y     [N+1];
  logic signed [W-1:0]              c_u     [N+1];
  logic signed [W-1:0]              c_v     [N+1];
  logic signed [ccf_pkg::ACC_W-1:0] c_acc   [N+1];
  ccf_pkg::ccf_side_t               c_side  [N+1];

  logic              p_valid;
  ccf_pkg::ccf_out_t p_data;

  logic              out_valid;
  ccf_pkg::ccf_out_t out_data;
  logic              skid_valid;
  ccf_pkg::ccf_out_t skid_data;
  logic              arrive, taken, load_out, load_skid, from_skid;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap <= 1'b0;
    end else if (cfg_we) begin
      wrap <= cfg_wdata;
    end
  end

  // chain advances while the skid entry is free
  assign ce           = !skid_valid;
  assign sample.ready = ce;

  ccf_prep #(.W(W), .F(F)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sample.valid),
    .in_data   (sample.data),
    .out_valid (c_valid[0]),
    .x         (c_x[0]),
    .y         (c_y[0]),
    .u         (c_u[0]),
    .v         (c_v[0]),
    .acc       (c_acc[0]),
    .side      (c_side[0])
  );

  // rotation cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    ccf_cell #(.W(W), .SHIFT(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (c_valid[i]),
      .in_x      (c_x[i]),
      .in_y      (c_y[i]),
      .in_u      (c_u[i]),
      .in_v      (c_v[i]),
      .in_acc    (c_acc[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_x     (c_x[i+1]),
      .out_y     (c_y[i+1]),
      .out_u     (c_u[i+1]),
      .out_v     (c_v[i+1]),
      .out_acc   (c_acc[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  ccf_scale #(.W(W), .F(F), .GAIN(GAIN)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .wrap      (wrap),
    .in_valid  (c_valid[N]),
    .in_x      (c_x[N]),
    .in_u      (c_u[N]),
    .in_v      (c_v[N]),
    .in_acc    (c_acc[N]),
    .in_side   (c_side[N]),
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  // output register and skid entry steering
  always_comb begin
    arrive    = p_valid && ce;
    taken     = out_valid && result.ready;
    from_skid = taken && skid_valid;
    load_out  = arrive && (!out_valid || taken);
    load_skid = arrive && out_valid && !result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (from_skid || load_out) begin
        out_valid <= 1'b1;
      end else if (taken) begin
        out_valid <= 1'b0;
      end
      if (from_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (from_skid) begin
      out_data <= skid_data;
    end else if (load_out) begin
      out_data <= p_data;
    end
    if (load_skid) begin
      skid_data <= p_data;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

FILE: rtl/ccf_prep.sv
module ccf_prep #(
  parameter int W = 50,
  parameter int F = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             ce,
  input  logic                             in_valid,
  input  ccf_pkg::ccf_in_t                 in_data,
  output logic                             out_valid,
  output logic signed [W-1:0]              x,
  output logic signed [W-1:0]              y,
  output logic signed [W-1:0]              u,
  output logic signed [W-1:0]              v,
  output logic signed [ccf_pkg::ACC_W-1:0] acc,
  output ccf_pkg::ccf_side_t               side
);

  localparam int EXT = W - ccf_pkg::DATA_W;

  logic signed [W-1:0] xe, ye, ue, ve;
  logic                flip;
  logic signed [W-1:0] x_next, y_next, u_next, v_next;
  logic signed [ccf_pkg::ACC_W-1:0] acc_next;
  ccf_pkg::ccf_side_t side_next;

  // scale to the internal grid and fold the left half plane by pi
  always_comb begin
    xe = {{EXT{in_data.pos_x[ccf_pkg::DATA_W-1]}}, in_data.pos_x} <<< F;
    ye = {{EXT{in_data.pos_y[ccf_pkg::DATA_W-1]}}, in_data.pos_y} <<< F;
    ue = {{EXT{in_data.field_x[ccf_pkg::DATA_W-1]}}, in_data.field_x} <<< F;
    ve = {{EXT{in_data.field_y[ccf_pkg::DATA_W-1]}}, in_data.field_y} <<< F;
    flip = in_data.pos_x[ccf_pkg::DATA_W-1];
    if (flip) begin
      x_next = -xe;
      y_next = -ye;
      u_next = -ue;
      v_next = -ve;
      acc_next = in_data.pos_y[ccf_pkg::DATA_W-1] ? -ccf_pkg::PI_Q30 : ccf_pkg::PI_Q30;
    end else begin
      x_next = xe;
      y_next = ye;
      u_next = ue;
      v_next = ve;
      acc_next = '0;
    end
    side_next.on_axis = (in_data.pos_x == '0) && (in_data.pos_y == '0);
    side_next.pos_z   = in_data.pos_z;
    side_next.field_x = in_data.field_x;
    side_next.field_y = in_data.field_y;
    side_next.field_z = in_data.field_z;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ce) begin
      x    <= x_next;
      y    <= y_next;
      u    <= u_next;
      v    <= v_next;
      acc  <= acc_next;
      side <= side_next;
    end
  end

endmodule

FILE: rtl/ccf_cell.sv
module ccf_cell #(
  parameter int W     = 50,
  parameter int SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             ce,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              in_x,
  input  logic signed [W-1:0]              in_y,
  input  logic signed [W-1:0]              in_u,
  input  logic signed [W-1:0]              in_v,
  input  logic signed [ccf_pkg::ACC_W-1:0] in_acc,
  input  ccf_pkg::ccf_side_t               in_side,
  output logic                             out_valid,
  output logic signed [W-1:0]              out_x,
  output logic signed [W-1:0]              out_y,
  output logic signed [W-1:0]              out_u,
  output logic signed [W-1:0]              out_v,
  output logic signed [ccf_pkg::ACC_W-1:0] out_acc,
  output ccf_pkg::ccf_side_t               out_side
);

  localparam logic signed [ccf_pkg::ACC_W-1:0] STEP_ANGLE =
    $signed({{(ccf_pkg::ACC_W - ccf_pkg::ATAN_W){1'b0}}, ccf_pkg::ATAN_Q30[SHIFT]});

  logic signed [W-1:0] xs, ys, us, vs;
  logic signed [W-1:0] x_next, y_next, u_next, v_next;
  logic signed [ccf_pkg::ACC_W-1:0] acc_next;

  // one micro-rotation, direction from the sign of y
  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    us = in_u >>> SHIFT;
    vs = in_v >>> SHIFT;
    if (!in_y[W-1]) begin
      x_next   = in_x + ys;
      y_next   = in_y - xs;
      u_next   = in_u + vs;
      v_next   = in_v - us;
      acc_next = in_acc + STEP_ANGLE;
    end else begin
      x_next   = in_x - ys;
      y_next   = in_y + xs;
      u_next   = in_u - vs;
      v_next   = in_v + us;
      acc_next = in_acc - STEP_ANGLE;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ce) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_u    <= u_next;
      out_v    <= v_next;
      out_acc  <= acc_next;
      out_side <= in_side;
    end
  end

endmodule

FILE: rtl/ccf_scale.sv
module ccf_scale #(
  parameter int                           W    = 50,
  parameter int                           F    = 16,
  parameter logic [ccf_pkg::GAIN_W-1:0]   GAIN = 31'd1304065748
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             ce,
  input  logic                             wrap,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              in_x,
  input  logic signed [W-1:0]              in_u,
  input  logic signed [W-1:0]              in_v,
  input  logic signed [ccf_pkg::ACC_W-1:0] in_acc,
  input  ccf_pkg::ccf_side_t               in_side,
  output logic                             out_valid,
  output ccf_pkg::ccf_out_t                out_data
);

  localparam int LANES = 3;
  localparam int LO_W  = 31;
  localparam int HI_W  = W - LO_W;
  localparam int PH_W  = HI_W + ccf_pkg::GAIN_W;
  localparam int PL_W  = LO_W + ccf_pkg::GAIN_W;
  localparam int T_W   = PH_W + 1;
  localparam int R_W   = T_W + 1 - F;
  localparam int DW    = ccf_pkg::DATA_W;
  localparam logic [T_W:0] HALF = (T_W+1)'(1) << (F - 1);

  // stage 1: magnitudes and rounded angle
  logic                 s1_valid;
  logic [W-1:0]         s1_mag [LANES];
  logic                 s1_neg [LANES];
  logic signed [DW-1:0] s1_ang;
  ccf_pkg::ccf_side_t   s1_side;

  // stage 2: partial products
  logic                 s2_valid;
  logic [PH_W-1:0]      s2_phi [LANES];
  logic [PL_W-1:0]      s2_plo [LANES];
  logic                 s2_neg [LANES];
  logic signed [DW-1:0] s2_ang;
  ccf_pkg::ccf_side_t   s2_side;

  // stage 3: rounded magnitudes
  logic                 s3_valid;
  logic [R_W-1:0]       s3_r [LANES];
  logic                 s3_neg [LANES];
  logic signed [DW-1:0] s3_ang;
  ccf_pkg::ccf_side_t   s3_side;

  logic signed [W-1:0]              lane_in [LANES];
  logic signed [ccf_pkg::ACC_W-1:0] acc_rnd;
  logic signed [DW-1:0]             ang_next;

  // lane order: radius, radial field, azimuthal field
  always_comb begin
    lane_in[0] = in_x;
    lane_in[1] = in_u;
    lane_in[2] = in_v;
    acc_rnd    = in_acc + ccf_pkg::ACC_W'(2);
    ang_next   = acc_rnd[ccf_pkg::ACC_W-1:2];
    if (ang_next > ccf_pkg::PI_Q28 || ang_next <= -ccf_pkg::PI_Q28) begin
      ang_next = ccf_pkg::PI_Q28;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (ce) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < LANES; i++) begin
        s1_neg[i] <= lane_in[i][W-1];
        s1_mag[i] <= lane_in[i][W-1] ? W'(-lane_in[i]) : W'(lane_in[i]);
        s2_phi[i] <= PH_W'(s1_mag[i][W-1:LO_W]) * PH_W'(GAIN);
        s2_plo[i] <= PL_W'(s1_mag[i][LO_W-1:0]) * PL_W'(GAIN);
        s2_neg[i] <= s1_neg[i];
        s3_r[i]   <= R_W'(((T_W+1)'(s2_phi[i]) + (T_W+1)'(s2_plo[i] >> LO_W) + HALF) >> F);
        s3_neg[i] <= s2_neg[i];
      end
      s1_ang  <= ang_next;
      s1_side <= in_side;
      s2_ang  <= s1_ang;
      s2_side <= s1_side;
      s3_ang  <= s2_ang;
      s3_side <= s2_side;
    end
  end

  logic [R_W-1:0]       clip [LANES];
  logic                 clipped [LANES];
  logic signed [DW-1:0] fld [LANES];
  logic signed [DW-1:0] ang_out;

  // saturation, sign, angle wrap and on-axis bypass
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      clip[i]    = s3_r[i];
      clipped[i] = 1'b0;
      if (s3_neg[i] && i != 0) begin
        if (s3_r[i] > R_W'(ccf_pkg::NEG_LIMIT)) begin
          clip[i]    = R_W'(ccf_pkg::NEG_LIMIT);
          clipped[i] = 1'b1;
        end
        fld[i] = -$signed(clip[i][DW-1:0]);
      end else begin
        if (s3_r[i] > R_W'(ccf_pkg::POS_LIMIT)) begin
          clip[i]    = R_W'(ccf_pkg::POS_LIMIT);
          clipped[i] = 1'b1;
        end
        fld[i] = $signed(clip[i][DW-1:0]);
      end
    end
    ang_out = s3_side.on_axis ? '0 : s3_ang;
    if (wrap && ang_out[DW-1]) begin
      ang_out = ang_out + ccf_pkg::TWO_PI_Q28;
    end
    out_valid                = s3_valid;
    out_data.azimuth         = ang_out;
    out_data.height          = s3_side.pos_z;
    out_data.field_axial     = s3_side.field_z;
    if (s3_side.on_axis) begin
      out_data.radius          = '0;
      out_data.field_radial    = s3_side.field_x;
      out_data.field_azimuthal = s3_side.field_y;
      out_data.saturated       = 1'b0;
    end else begin
      out_data.radius          = clip[0][ccf_pkg::RADIUS_W-1:0];
      out_data.field_radial    = fld[1];
      out_data.field_azimuthal = fld[2];
      out_data.saturated       = clipped[0] | clipped[1] | clipped[2];
    end
  end

endmodule

FILE: rtl/ccf_checker.sv
module ccf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ccf_pkg::ccf_out_t out_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input back-pressure only with a result waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a taken result frees the input side next cycle
  a_ready_recovers: assert property (@(posedge clk) disable iff (rst)
    out_ready |=> in_ready)
    else $error("input not ready after result transfer");

  // a full buffer stays full while the result is not taken
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready)
    else $error("buffered result lost while stalled");

endmodule

bind cartesian_to_cylindrical_field_unit ccf_checker u_ccf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
